// File: src/cfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfm_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int SLOT_W      = 16;
    localparam int COORD_W     = 32;
    localparam int HALF_W      = 30;
    localparam int RGB_W       = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_VERTEX   = 1'b0,
        KIND_TRIANGLE = 1'b1
    } kind_t;

    // corners touched by each face: top, front, left, back, right, bottom
    localparam logic [7:0] FACE_CORNERS [0:5] = '{
        8'h0F, 8'h33, 8'hAA, 8'hCC, 8'h55, 8'hF0
    };

    localparam logic [2:0] FACE_TRIS [0:5][0:5] = '{
        '{3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd2},
        '{3'd0, 3'd4, 3'd5, 3'd0, 3'd5, 3'd1},
        '{3'd1, 3'd5, 3'd3, 3'd5, 3'd7, 3'd3},
        '{3'd2, 3'd3, 3'd6, 3'd3, 3'd7, 3'd6},
        '{3'd0, 3'd2, 3'd4, 3'd2, 3'd6, 3'd4},
        '{3'd5, 3'd4, 3'd6, 3'd7, 3'd5, 3'd6}
    };

    // one classified cube waiting for the back end
    typedef struct packed {
        logic [5:0]                faces;
        logic [7:0]                used;
        logic [7:0][2:0]           rank;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [HALF_W-1:0]         half;
        logic [RGB_W-1:0]          upper;
        logic [RGB_W-1:0]          lower;
    } desc_t;

    function automatic logic [2:0] lowest_bit8(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // centre plus or minus half width, saturated to the signed 32-bit range
    function automatic logic [COORD_W-1:0] sat_offset(
        input logic signed [COORD_W-1:0] c,
        input logic [HALF_W-1:0]         h,
        input logic                      neg
    );
        logic [COORD_W:0] ext_c;
        logic [COORD_W:0] ext_h;
        logic [COORD_W:0] sum;
        logic [COORD_W-1:0] res;
        ext_c = {c[COORD_W-1], c};
        ext_h = (COORD_W + 1)'(h);
        sum   = neg ? (ext_c - ext_h) : (ext_c + ext_h);
        if (sum[COORD_W] != sum[COORD_W-1]) begin
            res = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            res = sum[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/cfm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfm_front
    import cfm_pkg::*;
(
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [5:0]                s_face_mask,
    input  wire logic signed [COORD_W-1:0] s_centre_x,
    input  wire logic signed [COORD_W-1:0] s_centre_y,
    input  wire logic signed [COORD_W-1:0] s_centre_z,
    input  wire logic [30:0]               s_edge_width,
    input  wire logic [RGB_W-1:0]          s_upper_rgb,
    input  wire logic [RGB_W-1:0]          s_lower_rgb,
    output logic                           push_valid,
    input  wire logic                      push_ready,
    output desc_t                          push_data
);

    logic [7:0]      used;
    logic [7:0][2:0] rank;

    always_comb begin
        used = 8'd0;
        for (int f = 0; f < 6; f++) begin
            if (s_face_mask[f]) begin
                used = used | FACE_CORNERS[f];
            end
        end
    end

    // compacted vertex index of each corner within this cube
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            rank[c] = 3'd0;
            for (int k = 0; k < c; k++) begin
                rank[c] = rank[c] + 3'(used[k]);
            end
        end
    end

    // empty cubes are taken and dropped here
    assign s_ready    = push_ready;
    assign push_valid = s_valid && (s_face_mask != 6'd0);

    always_comb begin
        push_data.faces = s_face_mask;
        push_data.used  = used;
        push_data.rank  = rank;
        push_data.cx    = s_centre_x;
        push_data.cy    = s_centre_y;
        push_data.cz    = s_centre_z;
        push_data.half  = s_edge_width[30:1];
        push_data.upper = s_upper_rgb;
        push_data.lower = s_lower_rgb;
    end

endmodule

`default_nettype wire

// File: src/cfm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cfm_queue
    import cfm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire desc_t push_data,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output desc_t      pop_data
);

    desc_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/cfm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfm_back
    import cfm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire desc_t               pop_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_kind,
    output logic [SLOT_W-1:0]        m_write_slot,
    output logic signed [COORD_W-1:0] m_out_x,
    output logic signed [COORD_W-1:0] m_out_y,
    output logic signed [COORD_W-1:0] m_out_z,
    output logic [RGB_W-1:0]         m_out_rgb,
    output logic [SLOT_W-1:0]        m_corner_a,
    output logic [SLOT_W-1:0]        m_corner_b,
    output logic [SLOT_W-1:0]        m_corner_c,
    output logic                     m_last
);

    // current cube
    logic                  active_reg, active_next;
    desc_t                 cur_reg, cur_next;
    logic [7:0]            rem_corners_reg, rem_corners_next;
    logic [5:0]            rem_faces_reg, rem_faces_next;
    logic                  half_reg, half_next;
    logic [INDEX_BITS-1:0] vbase_reg, vbase_next;
    logic [INDEX_BITS-1:0] vcnt_reg, vcnt_next;
    logic [INDEX_BITS-1:0] tcnt_reg, tcnt_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    kind_t                 kind_reg, kind_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [COORD_W-1:0]    x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [RGB_W-1:0]      rgb_reg, rgb_next;
    logic [SLOT_W-1:0]     ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic                  last_reg, last_next;

    logic                  out_free, emit, emit_last, vert_phase, load;
    logic [2:0]            corner, face, tri_base;
    logic [5:0]            face_bit;

    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = active_reg && out_free;
    assign vert_phase = (rem_corners_reg != 8'd0);
    assign corner     = lowest_bit8(rem_corners_reg);
    assign face       = lowest_bit8({2'b00, rem_faces_reg});
    assign face_bit   = 6'(1) << face;
    assign tri_base   = half_reg ? 3'd3 : 3'd0;
    // a vertex is never last: every cube with vertices has triangles after them
    assign emit_last  = !vert_phase && half_reg && ((rem_faces_reg & ~face_bit) == 6'd0);
    assign load       = pop_valid && (!active_reg || (emit && emit_last));
    assign pop_ready  = !active_reg || (emit && emit_last);

    always_comb begin
        active_next      = active_reg;
        cur_next         = cur_reg;
        rem_corners_next = rem_corners_reg;
        rem_faces_next   = rem_faces_reg;
        half_next        = half_reg;
        vbase_next       = vbase_reg;
        vcnt_next        = vcnt_reg;
        tcnt_next        = tcnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        kind_next        = kind_reg;
        slot_next        = slot_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        rgb_next         = rgb_reg;
        ca_next          = ca_reg;
        cb_next          = cb_reg;
        cc_next          = cc_reg;
        last_next        = last_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            if (vert_phase) begin
                kind_next = KIND_VERTEX;
                slot_next = SLOT_W'(vcnt_reg);
                x_next    = sat_offset(cur_reg.cx, cur_reg.half, !corner[0]);
                y_next    = sat_offset(cur_reg.cy, cur_reg.half, corner[2]);
                z_next    = sat_offset(cur_reg.cz, cur_reg.half, corner[1]);
                rgb_next  = corner[2] ? cur_reg.lower : cur_reg.upper;
                ca_next   = '0;
                cb_next   = '0;
                cc_next   = '0;
                last_next = 1'b0;
                vcnt_next = vcnt_reg + 1'b1;
                rem_corners_next = rem_corners_reg & ~(8'(1) << corner);
            end else begin
                kind_next = KIND_TRIANGLE;
                slot_next = SLOT_W'(tcnt_reg);
                x_next    = '0;
                y_next    = '0;
                z_next    = '0;
                rgb_next  = '0;
                ca_next   = SLOT_W'(vbase_reg +
                            INDEX_BITS'(cur_reg.rank[FACE_TRIS[face][tri_base]]));
                cb_next   = SLOT_W'(vbase_reg +
                            INDEX_BITS'(cur_reg.rank[FACE_TRIS[face][tri_base + 3'd1]]));
                cc_next   = SLOT_W'(vbase_reg +
                            INDEX_BITS'(cur_reg.rank[FACE_TRIS[face][tri_base + 3'd2]]));
                last_next = emit_last;
                tcnt_next = tcnt_reg + 1'b1;
                half_next = !half_reg;
                if (half_reg) begin
                    rem_faces_next = rem_faces_reg & ~face_bit;
                end
                if (emit_last) begin
                    active_next = 1'b0;
                end
            end
        end

        if (load) begin
            active_next      = 1'b1;
            cur_next         = pop_data;
            rem_corners_next = pop_data.used;
            rem_faces_next   = pop_data.faces;
            half_next        = 1'b0;
            // vertex phase of the previous cube is over whenever a load happens
            vbase_next       = vcnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            rem_corners_reg <= '0;
            rem_faces_reg   <= '0;
            half_reg        <= 1'b0;
            vcnt_reg        <= '0;
            tcnt_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            active_reg      <= active_next;
            rem_corners_reg <= rem_corners_next;
            rem_faces_reg   <= rem_faces_next;
            half_reg        <= half_next;
            vcnt_reg        <= vcnt_next;
            tcnt_reg        <= tcnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        vbase_reg <= vbase_next;
        kind_reg  <= kind_next;
        slot_reg  <= slot_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        rgb_reg   <= rgb_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        cc_reg    <= cc_next;
        last_reg  <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_write_slot = slot_reg;
    assign m_out_x      = x_reg;
    assign m_out_y      = y_reg;
    assign m_out_z      = z_reg;
    assign m_out_rgb    = rgb_reg;
    assign m_corner_a   = ca_reg;
    assign m_corner_b   = cb_reg;
    assign m_corner_c   = cc_reg;
    assign m_last       = last_reg;

    a_vert_has_faces: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && vert_phase) |-> (rem_faces_reg != 6'd0))
        else $error("vertex phase with no faces left");

    a_stay_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !emit_last) |=> active_reg)
        else $error("cube dropped before its last result");

    a_tri_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !vert_phase) |=> (tcnt_reg == $past(tcnt_reg) + 1'b1))
        else $error("triangle counter did not advance");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_last && !pop_valid) |=> !active_reg)
        else $error("still busy after last result with nothing queued");

endmodule

`default_nettype wire

// File: src/cube_face_mesh_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// a taken request is registered in the queue, then in the back-end cube register, then on m_
// throughput: one result per cycle while m_ready is high; a cube yields
//   (used corners + 2 x set faces) results, at most 20, from the back-end sequencer
// a cube with an empty face mask is taken while the queue has room and yields nothing
// reset: synchronous active-low aresetn empties the queue and clears both slot counters

module cube_face_mesh_emitter
    import cfm_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [5:0]                s_face_mask,
    input  wire logic signed [COORD_W-1:0] s_centre_x,
    input  wire logic signed [COORD_W-1:0] s_centre_y,
    input  wire logic signed [COORD_W-1:0] s_centre_z,
    input  wire logic [30:0]               s_edge_width,
    input  wire logic [RGB_W-1:0]          s_upper_rgb,
    input  wire logic [RGB_W-1:0]          s_lower_rgb,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_kind,
    output logic [SLOT_W-1:0]              m_write_slot,
    output logic signed [COORD_W-1:0]      m_out_x,
    output logic signed [COORD_W-1:0]      m_out_y,
    output logic signed [COORD_W-1:0]      m_out_z,
    output logic [RGB_W-1:0]               m_out_rgb,
    output logic [SLOT_W-1:0]              m_corner_a,
    output logic [SLOT_W-1:0]              m_corner_b,
    output logic [SLOT_W-1:0]              m_corner_c,
    output logic                           m_last
);

    logic  push_valid, push_ready, pop_valid, pop_ready;
    desc_t push_data, pop_data;

    cfm_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_face_mask  (s_face_mask),
        .s_centre_x   (s_centre_x),
        .s_centre_y   (s_centre_y),
        .s_centre_z   (s_centre_z),
        .s_edge_width (s_edge_width),
        .s_upper_rgb  (s_upper_rgb),
        .s_lower_rgb  (s_lower_rgb),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    cfm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cfm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_write_slot (m_write_slot),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_out_z      (m_out_z),
        .m_out_rgb    (m_out_rgb),
        .m_corner_a   (m_corner_a),
        .m_corner_b   (m_corner_b),
        .m_corner_c   (m_corner_c),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
